// ----- rtl/fss_pkg.sv -----
`timescale 1ns / 1ps

package fss_pkg;

	localparam int POS_W   = 5;
	localparam int SCORE_W = 10;
	localparam int OUT_W   = 11;
	localparam int CFG_W   = 64;
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
	localparam logic [IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
	localparam logic [IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

	localparam logic [SCORE_W-1:0] SCORE_BASE = 10'd10;
	localparam logic [SCORE_W-1:0] SCORE_RUN  = 10'd5;
	localparam logic [SCORE_W-1:0] SCORE_WORD = 10'd15;
	localparam logic signed [OUT_W-1:0] SCORE_NONE = -11'sd1;

	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic [SCORE_W-1:0] score;
		logic [POS_W-1:0]   run;
		logic               after_sep;
		logic               done;
	} name_state_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] score;
		logic                    matched;
	} result_t;

	localparam name_state_t NAME_START = '{pos: '0, score: '0, run: '0, after_sep: 1'b1,
		done: 1'b0};

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5A);
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return is_upper(c) ? c + 8'h20 : c;
	endfunction

	// punctuation or whitespace in the C locale
	function automatic logic is_separator(input logic [7:0] c);
		return ((c >= 8'h21) && (c <= 8'h2F)) || ((c >= 8'h3A) && (c <= 8'h40)) ||
			((c >= 8'h5B) && (c <= 8'h60)) || ((c >= 8'h7B) && (c <= 8'h7E)) ||
			((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
	endfunction

endpackage

// ----- rtl/fuzzy_subsequence_scorer.sv -----
`timescale 1ns / 1ps

// Fuzzy subsequence scorer: streams a candidate name one byte per request and
// scores it against the configured pattern, giving one result on the request
// marked last_char. A request enters an input register, from which a single
// compare-and-add step updates the per-name state and, on the last byte, loads
// the output register; a new request is taken every cycle unless in_stall is
// high, so the block runs at one byte per clock while it does not stall. The
// output register holds a result under out_stall; only a last byte waiting
// behind a held result backs up to in_stall. Write the pattern registers only
// while no name is in flight.
module fuzzy_subsequence_scorer #(
	parameter int PATTERN_MAX = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fss_pkg::IDX_W-1:0]          cfg_index,
	input  logic [fss_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         name_char,
	input  logic                               last_char,
	input  logic                               empty_name,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [fss_pkg::OUT_W-1:0]   match_score,
	output logic                               matched
);

	logic                       valid_s1;
	logic [7:0]                 char_s1;
	logic                       last_s1;
	logic                       empty_s1;
	fss_pkg::name_state_t       state_q;
	fss_pkg::name_state_t       state_nxt;
	fss_pkg::result_t           res;
	fss_pkg::result_t           res_q;
	logic                       out_valid_q;
	logic [7:0]                 pat_char;
	logic [fss_pkg::POS_W-1:0]  pat_len;
	logic                       go_s1;

	fss_pattern #(.PATTERN_MAX(PATTERN_MAX)) u_pattern (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pos      (state_q.pos),
		.pat_char (pat_char),
		.pat_len  (pat_len)
	);

	fss_step u_step (
		.cur       (state_q),
		.name_char (char_s1),
		.empty_name(empty_s1),
		.pat_char  (pat_char),
		.pat_len   (pat_len),
		.nxt       (state_nxt),
		.res       (res)
	);

	// a last byte cannot retire while the output register is held
	assign go_s1    = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1  <= name_char;
			last_s1  <= last_char;
			empty_s1 <= empty_name;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fss_pkg::NAME_START;
		end else if (go_s1) begin
			state_q <= last_s1 ? fss_pkg::NAME_START : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign match_score = res_q.score;
	assign matched     = res_q.matched;

endmodule

// ----- rtl/fss_pattern.sv -----
`timescale 1ns / 1ps

module fss_pattern #(
	parameter int PATTERN_MAX = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fss_pkg::IDX_W-1:0]     cfg_index,
	input  logic [fss_pkg::CFG_W-1:0]     cfg_data,
	input  logic [fss_pkg::POS_W-1:0]     pos,
	output logic [7:0]                    pat_char,
	output logic [fss_pkg::POS_W-1:0]     pat_len
);

	localparam int SEL_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam logic [fss_pkg::POS_W-1:0] LEN_MAX = fss_pkg::POS_W'(PATTERN_MAX);

	logic [7:0]                pat_q [PATTERN_MAX];
	logic [fss_pkg::POS_W-1:0] len_q;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_char
		localparam logic [fss_pkg::IDX_W-1:0] WORD_IDX =
			(i < 8) ? fss_pkg::CFG_PAT_LOW : fss_pkg::CFG_PAT_HIGH;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pat_q[i] <= '0;
			end else if (cfg_we && (cfg_index == WORD_IDX)) begin
				pat_q[i] <= cfg_data[8*(i%8) +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fss_pkg::CFG_PAT_LEN: len_q <= cfg_data[fss_pkg::POS_W-1:0];
				default: ;
			endcase
		end
	end

	// only looked at while pos is below the effective length
	assign pat_char = pat_q[pos[SEL_W-1:0]];
	assign pat_len  = (len_q > LEN_MAX) ? LEN_MAX : len_q;

endmodule

// ----- rtl/fss_step.sv -----
`timescale 1ns / 1ps

module fss_step (
	input  fss_pkg::name_state_t          cur,
	input  logic [7:0]                    name_char,
	input  logic                          empty_name,
	input  logic [7:0]                    pat_char,
	input  logic [fss_pkg::POS_W-1:0]     pat_len,
	output fss_pkg::name_state_t          nxt,
	output fss_pkg::result_t              res
);

	logic                         hit;
	logic [fss_pkg::POS_W-1:0]    pos_inc;
	logic [fss_pkg::SCORE_W-1:0]  gain;

	assign hit     = fss_pkg::fold_case(name_char) == fss_pkg::fold_case(pat_char);
	assign pos_inc = cur.pos + 1'b1;
	assign gain    = fss_pkg::SCORE_BASE
		+ fss_pkg::SCORE_W'(fss_pkg::SCORE_RUN * fss_pkg::SCORE_W'(cur.run))
		+ ((cur.after_sep || fss_pkg::is_upper(name_char)) ? fss_pkg::SCORE_WORD : '0);

	always_comb begin
		nxt = cur;
		if (!empty_name && (pat_len != '0) && !cur.done) begin
			if (cur.pos >= pat_len) begin
				// pattern got shorter under us
				nxt.done = 1'b1;
			end else begin
				if (hit) begin
					nxt.score = cur.score + gain;
					nxt.run   = cur.run + 1'b1;
					nxt.pos   = pos_inc;
					nxt.done  = pos_inc >= pat_len;
				end else begin
					nxt.run = '0;
				end
				nxt.after_sep = fss_pkg::is_separator(name_char);
			end
		end
	end

	always_comb begin
		if (pat_len == '0) begin
			res.score   = '0;
			res.matched = 1'b1;
		end else if (nxt.done) begin
			res.score   = fss_pkg::OUT_W'(nxt.score);
			res.matched = 1'b1;
		end else begin
			res.score   = fss_pkg::SCORE_NONE;
			res.matched = 1'b0;
		end
	end

endmodule

// ----- dv/tb_fuzzy_subsequence_scorer.sv -----
`timescale 1ns / 1ps

module tb_fuzzy_subsequence_scorer;

	localparam int PATTERN_MAX = 16;
	localparam int NAME_PHASES = 14;
	localparam int PHASE_BYTES = 110;
	localparam logic [fss_pkg::IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       empty;
	} name_req_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [fss_pkg::IDX_W-1:0] cfg_index = '0;
	logic [fss_pkg::CFG_W-1:0] cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         name_char = '0;
	logic               last_char = 1'b0;
	logic               empty_name = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [fss_pkg::OUT_W-1:0] match_score;
	logic               matched;

	// pattern registers as the block should hold them
	logic [63:0] pat_low = '0;
	logic [63:0] pat_high = '0;
	logic [4:0]  pat_len = '0;

	// per-name scoring state
	logic [fss_pkg::POS_W-1:0]   nm_pos = '0;
	logic [fss_pkg::SCORE_W-1:0] nm_sum = '0;
	logic [fss_pkg::POS_W-1:0]   nm_run = '0;
	logic               nm_after_sep = 1'b1;
	logic               nm_done = 1'b0;

	name_req_t          req_q[$];
	fss_pkg::result_t   score_q[$];

	int item_count = 0;
	int fail_count = 0;
	int send_gap = 0;
	int stall_left = 0;
	int long_hold = 0;
	int hold_ask = 0;
	int hold_seen = 0;
	bit calm = 1'b0;

	always #10 clk = ~clk;

	fuzzy_subsequence_scorer #(.PATTERN_MAX(PATTERN_MAX)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.name_char  (name_char),
		.last_char  (last_char),
		.empty_name (empty_name),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.match_score(match_score),
		.matched    (matched)
	);

	function automatic logic [7:0] lower_of(input logic [7:0] c);
		return (c inside {[8'h41:8'h5A]}) ? (c | 8'h20) : c;
	endfunction

	function automatic logic is_gap(input logic [7:0] c);
		return c inside {[8'h09:8'h0D], 8'h20, [8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60],
			[8'h7B:8'h7E]};
	endfunction

	function automatic int pattern_span();
		return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
	endfunction

	// advance the name state by one request, queue the score on the last byte
	function automatic void score_byte(input logic [7:0] c, input logic last,
			input logic no_byte);
		logic [127:0] pat_all;
		logic [7:0] pc;
		int span;
		fss_pkg::result_t res;
		pat_all = {pat_high, pat_low};
		span = pattern_span();
		if (!no_byte && span != 0 && !nm_done) begin
			if (nm_pos >= span) begin
				// pattern got shorter while the name was in flight
				nm_done = 1'b1;
			end else begin
				pc = pat_all[nm_pos[3:0]*8 +: 8];
				if (lower_of(c) == lower_of(pc)) begin
					nm_sum = nm_sum + fss_pkg::SCORE_BASE + fss_pkg::SCORE_RUN * nm_run;
					if (nm_after_sep || (c inside {[8'h41:8'h5A]}))
						nm_sum = nm_sum + fss_pkg::SCORE_WORD;
					nm_run = nm_run + 1'b1;
					nm_pos = nm_pos + 1'b1;
					if (nm_pos >= span)
						nm_done = 1'b1;
				end else begin
					nm_run = '0;
				end
				nm_after_sep = is_gap(c);
			end
		end
		if (last) begin
			if (span == 0) begin
				res.score = '0;
				res.matched = 1'b1;
			end else if (nm_done) begin
				res.score = {1'b0, nm_sum};
				res.matched = 1'b1;
			end else begin
				res.score = fss_pkg::SCORE_NONE;
				res.matched = 1'b0;
			end
			score_q.push_back(res);
			nm_pos = '0;
			nm_sum = '0;
			nm_run = '0;
			nm_after_sep = 1'b1;
			nm_done = 1'b0;
		end
	endfunction

	// mostly letters of both cases and separators, with some arbitrary bytes
	function automatic logic [7:0] any_byte();
		case ($urandom_range(0, 5))
			0, 1: return 8'h61 + 8'($urandom_range(0, 25));
			2: return 8'h41 + 8'($urandom_range(0, 25));
			3: begin
				case ($urandom_range(0, 3))
					0: return 8'h21 + 8'($urandom_range(0, 14));
					1: return 8'h3A + 8'($urandom_range(0, 6));
					2: return 8'h5B + 8'($urandom_range(0, 5));
					default: return ($urandom_range(0, 1) != 0) ? 8'h20 :
						8'h09 + 8'($urandom_range(0, 4));
				endcase
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_byte(input logic [7:0] ch, input logic last, input logic empty);
		name_req_t req;
		req.ch = ch;
		req.last = last;
		req.empty = empty;
		req_q.push_back(req);
		if (!(empty && !last))
			item_count++;
	endtask

	task automatic queue_name();
		logic [7:0] body[$];
		logic [127:0] pat_all;
		logic [7:0] b;
		int span, kind, drop_at;
		pat_all = {pat_high, pat_low};
		span = pattern_span();
		kind = $urandom_range(0, 19);
		drop_at = (kind == 4 || kind == 5) ? $urandom_range(0, 15) : -1;
		if (kind == 0) begin
			push_byte(any_byte(), 1'b1, 1'b1);
		end else begin
			if (kind <= 3) begin
				repeat ($urandom_range(1, 8)) body.push_back(any_byte());
			end else begin
				for (int i = 0; i < span; i++) begin
					if ($urandom_range(0, 3) == 0)
						repeat ($urandom_range(1, 3)) body.push_back(any_byte());
					if (i != drop_at) begin
						b = pat_all[i*8 +: 8];
						if (lower_of(b) inside {[8'h61:8'h7A]} && $urandom_range(0, 1) != 0)
							b = b ^ 8'h20;
						body.push_back(b);
					end
				end
				repeat ($urandom_range(0, 3)) body.push_back(any_byte());
			end
			if (body.size() == 0)
				body.push_back(any_byte());
			foreach (body[i]) begin
				if ($urandom_range(0, 19) == 0)
					push_byte(any_byte(), 1'b0, 1'b1);
				push_byte(body[i], i == body.size() - 1, 1'b0);
			end
		end
	endtask

	task automatic write_reg(input logic [fss_pkg::IDX_W-1:0] idx,
			input logic [fss_pkg::CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			fss_pkg::CFG_PAT_LOW: pat_low = data;
			fss_pkg::CFG_PAT_HIGH: pat_high = data;
			fss_pkg::CFG_PAT_LEN: pat_len = data[4:0];
			default: ;
		endcase
	endtask

	task automatic close_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_pattern(input logic [63:0] low, input logic [63:0] high,
			input logic [4:0] len);
		logic [63:0] junk;
		junk = {$urandom(), $urandom()};
		write_reg(fss_pkg::CFG_PAT_LOW, low);
		write_reg(CFG_SPARE, junk);
		write_reg(fss_pkg::CFG_PAT_HIGH, high);
		// upper bits of the length write carry junk
		write_reg(fss_pkg::CFG_PAT_LEN, {junk[63:5], len});
		close_writes();
	endtask

	// no request pending or in flight and every score collected
	task automatic wait_idle();
		do @(negedge clk);
		while (req_q.size() != 0 || in_valid || score_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// request side
	always @(posedge clk) begin
		name_req_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall)
				score_byte(name_char, last_char, empty_name);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (req_q.size() > 0) begin
					nxt = req_q.pop_front();
					name_char <= nxt.ch;
					last_char <= nxt.last;
					empty_name <= nxt.empty;
					in_valid <= 1'b1;
					if (!calm && $urandom_range(0, 15) == 0)
						send_gap = $urandom_range(1, 12);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// score side
	always @(posedge clk) begin
		fss_pkg::result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (score_q.size() == 0) begin
					$error("unexpected score: match_score %0d matched %0b",
						match_score, matched);
					fail_count++;
				end else begin
					want = score_q.pop_front();
					if (match_score !== want.score) begin
						$error("match_score: expected %0d, got %0d",
							$signed(want.score), match_score);
						fail_count++;
					end
					if (matched !== want.matched) begin
						$error("matched: expected %0b, got %0b", want.matched, matched);
						fail_count++;
					end
				end
			end
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				long_hold = 300;
			end
			if (long_hold > 0) begin
				long_hold--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 11);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [127:0] chars;
		logic [4:0] len;
		int start;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty pattern straight out of reset
		push_byte(8'h61, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b1, 1'b0);
		push_byte(8'h00, 1'b1, 1'b1);
		wait_idle();

		// pattern "aB", 0xC3, "z": word starts, case folding, high byte
		load_pattern(64'h0000_0000_7AC3_4261, 64'h8000_0000_0000_0001, 5'd4);
		push_byte(8'h2D, 1'b0, 1'b0);
		push_byte(8'h41, 1'b0, 1'b0);
		push_byte(8'h62, 1'b0, 1'b0);
		push_byte(8'h09, 1'b0, 1'b0);
		push_byte(8'hC3, 1'b0, 1'b0);
		push_byte(8'h55, 1'b0, 1'b1);
		push_byte(8'h5A, 1'b0, 1'b0);
		push_byte(8'h00, 1'b1, 1'b0);
		// 0xE3 must not fold onto 0xC3
		push_byte(8'h61, 1'b0, 1'b0);
		push_byte(8'hE3, 1'b1, 1'b0);
		push_byte(8'h7F, 1'b1, 1'b1);
		wait_idle();

		// oversized length clamps to sixteen, all upper case gives the top score
		load_pattern({8{8'h71}}, {8{8'h71}}, 5'd31);
		for (int i = 0; i < PATTERN_MAX; i++)
			push_byte(8'h51, i == PATTERN_MAX - 1, 1'b0);
		wait_idle();

		// shorten the pattern while a name is half done
		write_reg(fss_pkg::CFG_PAT_LEN, 64'd3);
		close_writes();
		push_byte(8'h71, 1'b0, 1'b0);
		push_byte(8'h71, 1'b0, 1'b0);
		wait_idle();
		write_reg(fss_pkg::CFG_PAT_LEN, 64'd1);
		close_writes();
		push_byte(8'h72, 1'b1, 1'b0);
		wait_idle();

		for (int ph = 0; ph < NAME_PHASES; ph++) begin
			for (int i = 0; i < 16; i++)
				chars[i*8 +: 8] = any_byte();
			case (ph)
				0: len = 5'd16;
				1: len = 5'd31;
				2: len = 5'd0;
				3: begin
					len = 5'd16;
					chars = '1;
				end
				4: begin
					len = 5'd8;
					chars = '0;
				end
				default: len = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31)) :
					5'($urandom_range(1, 16));
			endcase
			load_pattern(chars[63:0], chars[127:64], len);
			if (ph == 6)
				hold_ask++;
			if (ph >= NAME_PHASES - 2)
				calm = 1'b1;
			start = item_count;
			while (item_count - start < PHASE_BYTES)
				queue_name();
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/fss_pkg.sv
rtl/fss_pattern.sv
rtl/fss_step.sv
rtl/fuzzy_subsequence_scorer.sv
dv/tb_fuzzy_subsequence_scorer.sv
